/* rtl/tfq_pkg.sv */
// shared constants and codes for the transmit frame queue with batch submitter
package tfq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int BATCH_MAX     = 16;
    localparam int PAYLOAD_WIDTH = 64;

    localparam int OP_W       = 2;
    localparam int CMD_W      = 16;
    localparam int PAY_PORT_W = 64;
    localparam int LINK_W     = 2;
    localparam int SEQ_W      = 8;
    localparam int LEVEL_W    = 7;
    localparam int CTR_W      = 32;

    localparam int TAG_W  = CMD_W + SEQ_W;
    localparam int WORD_W = TAG_W + PAYLOAD_WIDTH;

    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BIDX_W = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int BCNT_W = $clog2(BATCH_MAX + 1);

    localparam logic [OP_W-1:0] OP_ENQUEUE    = 2'd0;
    localparam logic [OP_W-1:0] OP_SUBMIT     = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPLETE   = 2'd2;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd3;

    localparam logic [LINK_W-1:0] LINK_ACCEPT = 2'd0;
    localparam logic [LINK_W-1:0] LINK_BUSY   = 2'd1;

endpackage

/* rtl/tx_frame_queue_batch_submitter_core.sv */
// top level: frame queue and batch memories with the submit sequencer and counters
// results: enqueue, complete, disconnect and refused submits give one result in the cycle
//   after start; a submit that fills moves its frames in the fill state, then decides
// throughput: an accepted submit of n frames puts out n results on consecutive cycles,
//   one batch memory read each
// reset: asynchronous, clears pointers, counts, counters and the sequencer; the memories
//   are not cleared, results are never held off by the receiver
module tx_frame_queue_batch_submitter_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tfq_pkg::OP_W-1:0]       op,
    input  logic [tfq_pkg::CMD_W-1:0]      command_id,
    input  logic [tfq_pkg::PAY_PORT_W-1:0] payload,
    input  logic [tfq_pkg::LINK_W-1:0]     link_status,
    output logic                           strobe,
    output logic                           kind,
    output logic [tfq_pkg::PAY_PORT_W-1:0] frame_payload,
    output logic [tfq_pkg::CMD_W-1:0]      frame_command,
    output logic [tfq_pkg::SEQ_W-1:0]      frame_seq,
    output logic                           last,
    output logic [tfq_pkg::LEVEL_W-1:0]    queue_level,
    output logic [tfq_pkg::CTR_W-1:0]      dropped_total,
    output logic [tfq_pkg::CTR_W-1:0]      queued_total,
    output logic [tfq_pkg::CTR_W-1:0]      complete_total,
    output logic [tfq_pkg::CTR_W-1:0]      busy_total,
    output logic [tfq_pkg::CTR_W-1:0]      error_total,
    output logic                           link_active
);

    import tfq_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FILL   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [QIDX_W-1:0] rp_reg, rp_next;
    logic [QIDX_W-1:0] wp_reg, wp_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [BCNT_W-1:0] pending_reg, pending_next;
    logic [BCNT_W-1:0] frames_reg, frames_next;
    logic              link_busy_reg, link_busy_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [CTR_W-1:0]  dropped_reg, dropped_next;
    logic [CTR_W-1:0]  queued_reg, queued_next;
    logic [CTR_W-1:0]  complete_reg, complete_next;
    logic [CTR_W-1:0]  busyc_reg, busyc_next;
    logic [CTR_W-1:0]  error_reg, error_next;
    logic [LINK_W-1:0] link_reg, link_next;
    logic [BCNT_W-1:0] cnt_reg, cnt_next;
    logic [BCNT_W-1:0] total_reg, total_next;
    logic              wr_valid_reg, wr_valid_next;
    logic [BIDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic              strobe_reg, strobe_next;
    logic              kind_reg, kind_next;
    logic              last_reg, last_next;

    logic              q_we;
    logic [WORD_W-1:0] q_wdata;
    logic              q_re;
    logic [WORD_W-1:0] q_rdata;
    logic              b_re;
    logic [WORD_W-1:0] b_rdata;

    logic              decide;
    logic [LINK_W-1:0] dec_link;
    logic [BCNT_W-1:0] fill_total;

    function automatic logic [QIDX_W-1:0] qinc(input logic [QIDX_W-1:0] p);
        qinc = (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : QIDX_W'(p + 1'b1);
    endfunction

    tfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (wp_reg),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (rp_reg),
        .rdata (q_rdata)
    );

    tfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BATCH_MAX)
    ) u_batch_ram (
        .clk   (clk),
        .we    (wr_valid_reg),
        .waddr (wr_idx_reg),
        .wdata (q_rdata),
        .re    (b_re),
        .raddr (cnt_reg[BIDX_W-1:0]),
        .rdata (b_rdata)
    );

    assign q_wdata    = {command_id, seq_reg, payload[PAYLOAD_WIDTH-1:0]};
    assign fill_total = (int'(count_reg) > BATCH_MAX) ? BCNT_W'(BATCH_MAX)
                                                      : BCNT_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        frames_next    = frames_reg;
        link_busy_next = link_busy_reg;
        seq_next       = seq_reg;
        dropped_next   = dropped_reg;
        queued_next    = queued_reg;
        complete_next  = complete_reg;
        busyc_next     = busyc_reg;
        error_next     = error_reg;
        link_next      = link_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        wr_valid_next  = 1'b0;
        wr_idx_next    = wr_idx_reg;
        strobe_next    = 1'b0;
        kind_next      = 1'b0;
        last_next      = 1'b1;
        q_we           = 1'b0;
        q_re           = 1'b0;
        b_re           = 1'b0;
        decide         = 1'b0;
        dec_link       = link_status;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_ENQUEUE:
                        begin
                            q_we = 1'b1;
                            if (int'(count_reg) == QUEUE_DEPTH)
                            begin
                                rp_next      = qinc(rp_reg);
                                dropped_next = dropped_reg + 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            wp_next     = qinc(wp_reg);
                            seq_next    = seq_reg + 1'b1;
                            queued_next = queued_reg + 1'b1;
                            strobe_next = 1'b1;
                        end
                        OP_SUBMIT:
                        begin
                            if (link_busy_reg)
                            begin
                                strobe_next = 1'b1;
                            end
                            else if (pending_reg != '0)
                            begin
                                decide   = 1'b1;
                                dec_link = link_status;
                            end
                            else if (count_reg != '0)
                            begin
                                total_next   = fill_total;
                                pending_next = fill_total;
                                frames_next  = fill_total;
                                cnt_next     = '0;
                                link_next    = link_status;
                                state_next   = ST_FILL;
                            end
                            else
                            begin
                                frames_next = '0;
                                strobe_next = 1'b1;
                            end
                        end
                        OP_COMPLETE:
                        begin
                            if (link_busy_reg)
                            begin
                                complete_next = complete_reg + CTR_W'(frames_reg);
                            end
                            frames_next    = '0;
                            link_busy_next = 1'b0;
                            strobe_next    = 1'b1;
                        end
                        default:
                        begin
                            dropped_next   = dropped_reg + CTR_W'(frames_reg);
                            frames_next    = '0;
                            pending_next   = '0;
                            link_busy_next = 1'b0;
                            strobe_next    = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                q_re          = 1'b1;
                rp_next       = qinc(rp_reg);
                count_next    = count_reg - 1'b1;
                wr_valid_next = 1'b1;
                wr_idx_next   = cnt_reg[BIDX_W-1:0];
                cnt_next      = BCNT_W'(cnt_reg + 1'b1);
                if (BCNT_W'(cnt_reg + 1'b1) == total_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                decide   = 1'b1;
                dec_link = link_reg;
            end
            ST_EMIT:
            begin
                b_re        = 1'b1;
                strobe_next = 1'b1;
                kind_next   = 1'b1;
                last_next   = (BCNT_W'(cnt_reg + 1'b1) == total_reg);
                cnt_next    = BCNT_W'(cnt_reg + 1'b1);
                if (last_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (decide)
        begin
            case (dec_link)
                LINK_ACCEPT:
                begin
                    link_busy_next = 1'b1;
                    total_next     = pending_reg;
                    pending_next   = '0;
                    cnt_next       = '0;
                    state_next     = ST_EMIT;
                end
                LINK_BUSY:
                begin
                    busyc_next  = busyc_reg + 1'b1;
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                default:
                begin
                    error_next   = error_reg + 1'b1;
                    dropped_next = dropped_reg + CTR_W'(frames_reg);
                    frames_next  = '0;
                    pending_next = '0;
                    strobe_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            pending_reg   <= '0;
            frames_reg    <= '0;
            link_busy_reg <= 1'b0;
            seq_reg       <= '0;
            dropped_reg   <= '0;
            queued_reg    <= '0;
            complete_reg  <= '0;
            busyc_reg     <= '0;
            error_reg     <= '0;
            link_reg      <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            wr_valid_reg  <= 1'b0;
            wr_idx_reg    <= '0;
            strobe_reg    <= 1'b0;
            kind_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            frames_reg    <= frames_next;
            link_busy_reg <= link_busy_next;
            seq_reg       <= seq_next;
            dropped_reg   <= dropped_next;
            queued_reg    <= queued_next;
            complete_reg  <= complete_next;
            busyc_reg     <= busyc_next;
            error_reg     <= error_next;
            link_reg      <= link_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            wr_valid_reg  <= wr_valid_next;
            wr_idx_reg    <= wr_idx_next;
            strobe_reg    <= strobe_next;
            kind_reg      <= kind_next;
            last_reg      <= last_next;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign strobe         = strobe_reg;
    assign kind           = kind_reg;
    assign last           = last_reg;
    assign frame_payload  = kind_reg ? PAY_PORT_W'(b_rdata[PAYLOAD_WIDTH-1:0]) : '0;
    assign frame_command  = kind_reg ? b_rdata[WORD_W-1 -: CMD_W] : '0;
    assign frame_seq      = kind_reg ? b_rdata[PAYLOAD_WIDTH +: SEQ_W] : '0;
    assign queue_level    = LEVEL_W'(count_reg);
    assign dropped_total  = dropped_reg;
    assign queued_total   = queued_reg;
    assign complete_total = complete_reg;
    assign busy_total     = busyc_reg;
    assign error_total    = error_reg;
    assign link_active    = link_busy_reg;

    // a transmitted frame word is only shown while the link holds the batch
    a_frame_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && kind_reg |-> link_busy_reg)
        else $error("frame word without active link");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= QUEUE_DEPTH)
        else $error("queue level beyond depth");

    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pending_reg) <= BATCH_MAX && int'(frames_reg) <= BATCH_MAX)
        else $error("batch count beyond limit");

    // batch writes only follow queue reads of a fill
    a_batch_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> state_reg == ST_FILL || state_reg == ST_DECIDE)
        else $error("batch write outside fill");

    a_no_word_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> !strobe_reg)
        else $error("word shown during fill");

endmodule

/* rtl/tfq_ram.sv */
// generic simple dual-port ram, one write port, one registered read port
module tfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
